/* rtl/core/qmn_pkg.sv */
// Package for the normalised quaternion product pipeline.
// Holds the field widths, fixed-point constants and stage counts; no dependencies.
package qmn_pkg;

  localparam int unsigned QW       = 16;  // Q1.14 field width
  localparam int unsigned PRODW    = 32;  // one partial product
  localparam int unsigned SUMW     = 34;  // signed product component
  localparam int unsigned MAGW     = 33;  // magnitude of a component
  localparam int unsigned SHW      = 31;  // normalised magnitude, top bit at 30
  localparam int unsigned SQW      = 62;  // square of a normalised magnitude
  localparam int unsigned RADW     = 64;  // sum of squares
  localparam int unsigned ROOTW    = 32;  // integer square root
  localparam int unsigned SREMW    = 34;  // square-root remainder
  localparam int unsigned SQ_STEPS = 32;  // one root bit per stage
  localparam int unsigned NUMW     = 47;  // dividend m * 2^15 + mag
  localparam int unsigned DENW     = 33;  // divisor 2 * mag
  localparam int unsigned QUOW     = 17;  // quotient width
  localparam int unsigned DV_STEPS = 17;  // one quotient bit per stage
  localparam int unsigned LZW      = 6;   // leading-zero count, 0..33

  localparam logic [QUOW-1:0] QONE = QUOW'(16384);

  // Side data that travels with a transaction through the root and divide chains
  typedef struct packed {
    logic [3:0][SHW-1:0] m;
    logic [3:0]          neg;
    logic                zero;
  } item_t;

endpackage

/* rtl/core/quaternion_multiply_normalize.sv */
// Top level: Hamilton product of two Q1.14 quaternions, normalised to unit length.
// Depends on qmn_pkg for widths, constants and the side-data struct.
//
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | a_w a_i a_j a_k b_w b_i b_j b_k
//  out_    | output    | out_valid / out_ready  | r_w r_i r_j r_k zero_product
//
// One transaction per cycle; stages: 7 front stages, 32 square-root stages at one
// root bit each, 17 divide stages at one quotient bit each, then the output.
// The whole pipeline moves together: it advances when the output register is empty
// or being taken, so a stalled output freezes every stage and nothing is lost.
// Synchronous active-low reset clears the valid bits only.
module quaternion_multiply_normalize
  import qmn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [QW-1:0] in_a_w,
  input  logic signed [QW-1:0] in_a_i,
  input  logic signed [QW-1:0] in_a_j,
  input  logic signed [QW-1:0] in_a_k,
  input  logic signed [QW-1:0] in_b_w,
  input  logic signed [QW-1:0] in_b_i,
  input  logic signed [QW-1:0] in_b_j,
  input  logic signed [QW-1:0] in_b_k,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [QW-1:0] out_r_w,
  output logic signed [QW-1:0] out_r_i,
  output logic signed [QW-1:0] out_r_j,
  output logic signed [QW-1:0] out_r_k,
  output logic                 out_zero_product
);

  logic en;
  logic out_valid_r;
  logic signed [QW-1:0] out_r_r [4];
  logic out_zero_r;

  // global advance
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------- stage 1: sixteen partial products
  logic signed [PRODW-1:0] prod_r [16];
  logic v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0]  <= in_a_w * in_b_w;
      prod_r[1]  <= in_a_i * in_b_i;
      prod_r[2]  <= in_a_j * in_b_j;
      prod_r[3]  <= in_a_k * in_b_k;
      prod_r[4]  <= in_a_w * in_b_i;
      prod_r[5]  <= in_a_i * in_b_w;
      prod_r[6]  <= in_a_j * in_b_k;
      prod_r[7]  <= in_a_k * in_b_j;
      prod_r[8]  <= in_a_w * in_b_j;
      prod_r[9]  <= in_a_i * in_b_k;
      prod_r[10] <= in_a_j * in_b_w;
      prod_r[11] <= in_a_k * in_b_i;
      prod_r[12] <= in_a_w * in_b_k;
      prod_r[13] <= in_a_i * in_b_j;
      prod_r[14] <= in_a_j * in_b_i;
      prod_r[15] <= in_a_k * in_b_w;
    end
  end

  // ---------------- stage 2: product components
  logic signed [SUMW-1:0] p_r [4];
  logic signed [SUMW-1:0] pe [16];
  logic v2_r;

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      pe[n] = SUMW'(prod_r[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= pe[0]  - pe[1]  - pe[2]  - pe[3];
      p_r[1] <= pe[4]  + pe[5]  + pe[6]  - pe[7];
      p_r[2] <= pe[8]  - pe[9]  + pe[10] + pe[11];
      p_r[3] <= pe[12] + pe[13] - pe[14] + pe[15];
    end
  end

  // ---------------- stage 3: sign and magnitude, OR of magnitudes
  logic [MAGW-1:0] m3_r [4];
  logic [3:0]      neg3_r;
  logic [MAGW-1:0] or3_r;
  logic [MAGW-1:0] m3_nxt [4];
  logic [SUMW-1:0] abs3 [4];
  logic v3_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      abs3[c]   = p_r[c][SUMW-1] ? SUMW'(-p_r[c]) : SUMW'(p_r[c]);
      m3_nxt[c] = abs3[c][MAGW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        m3_r[c]   <= m3_nxt[c];
        neg3_r[c] <= p_r[c][SUMW-1];
      end
      or3_r <= m3_nxt[0] | m3_nxt[1] | m3_nxt[2] | m3_nxt[3];
    end
  end

  // ---------------- stage 4: leading-zero count of the largest magnitude
  logic [LZW-1:0]  lz_nxt;
  logic [LZW-1:0]  lz4_r;
  logic [MAGW-1:0] m4_r [4];
  logic [3:0]      neg4_r;
  logic            zero4_r;
  logic v4_r;

  always_comb begin
    lz_nxt = LZW'(MAGW);
    for (int b = 0; b < MAGW; b++) begin
      if (or3_r[b]) lz_nxt = LZW'(MAGW - 1 - b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lz4_r   <= lz_nxt;
      m4_r    <= m3_r;
      neg4_r  <= neg3_r;
      zero4_r <= (or3_r == '0);
    end
  end

  // ---------------- stage 5: common shift, top bit of the largest lands at 30
  item_t it5_r;
  logic [MAGW-1:0] shl5 [4];
  logic v5_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      shl5[c] = m4_r[c] << lz4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        it5_r.m[c] <= shl5[c][MAGW-1:2];
      end
      it5_r.neg  <= neg4_r;
      it5_r.zero <= zero4_r;
    end
  end

  // ---------------- stage 6: squares
  logic [SQW-1:0] sq6_r [4];
  item_t it6_r;
  logic v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        sq6_r[c] <= it5_r.m[c] * it5_r.m[c];
      end
      it6_r <= it5_r;
    end
  end

  // ---------------- stage 7: sum of squares
  logic [RADW-1:0] s7_r;
  item_t it7_r;
  logic v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r  <= RADW'(sq6_r[0]) + RADW'(sq6_r[1]) + RADW'(sq6_r[2]) + RADW'(sq6_r[3]);
      it7_r <= it6_r;
    end
  end

  // ---------------- square-root chain, one root bit per stage
  logic [SREMW-1:0] sr_rem  [SQ_STEPS+1];
  logic [ROOTW-1:0] sr_root [SQ_STEPS+1];
  logic [RADW-1:0]  sr_rad  [SQ_STEPS+1];
  item_t            sr_it   [SQ_STEPS+1];
  logic             sr_v    [SQ_STEPS+1];

  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_rad[0]  = s7_r;
  assign sr_it[0]   = it7_r;
  assign sr_v[0]    = v7_r;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [SREMW+1:0] rem_sh;
    logic [SREMW+1:0] trial;
    logic             take;

    assign rem_sh = {sr_rem[k], sr_rad[k][RADW-1 -: 2]};
    assign trial  = {2'b00, sr_root[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v[k+1] <= 1'b0;
      end else if (en) begin
        sr_v[k+1] <= sr_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem[k+1]  <= take ? SREMW'(rem_sh - trial) : SREMW'(rem_sh);
        sr_root[k+1] <= {sr_root[k][ROOTW-2:0], take};
        sr_rad[k+1]  <= {sr_rad[k][RADW-3:0], 2'b00};
        sr_it[k+1]   <= sr_it[k];
      end
    end
  end

  // ---------------- divide chain, four lanes, one quotient bit per stage
  logic [NUMW-1:0] dv_rem [DV_STEPS+1][4];
  logic [QUOW-1:0] dv_quo [DV_STEPS+1][4];
  logic [DENW-1:0] dv_den [DV_STEPS+1];
  item_t           dv_it  [DV_STEPS+1];
  logic            dv_v   [DV_STEPS+1];

  // rounding: floor((m * 2^15 + mag) / (2 * mag))
  for (genvar c = 0; c < 4; c++) begin : g_num
    assign dv_rem[0][c] = {sr_it[SQ_STEPS].m[c], 15'b0} + NUMW'(sr_root[SQ_STEPS]);
    assign dv_quo[0][c] = '0;
  end
  assign dv_den[0] = {sr_root[SQ_STEPS], 1'b0};
  assign dv_it[0]  = sr_it[SQ_STEPS];
  assign dv_v[0]   = sr_v[SQ_STEPS];

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_div
    localparam int unsigned SH = DV_STEPS - 1 - k;
    logic [NUMW+2:0] trial;

    assign trial = (NUMW+3)'(dv_den[k]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
      logic [NUMW+2:0] rem_x;
      logic            take;

      assign rem_x = (NUMW+3)'(dv_rem[k][c]);
      assign take  = (rem_x >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1][c] <= take ? NUMW'(rem_x - trial) : dv_rem[k][c];
          dv_quo[k+1][c] <= {dv_quo[k][c][QUOW-2:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[k+1] <= dv_den[k];
        dv_it[k+1]  <= dv_it[k];
      end
    end
  end

  // ---------------- output register: saturate, sign, zero case
  logic [QUOW-1:0]      qs [4];
  logic signed [QW-1:0] r_nxt [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qs[c] = (dv_quo[DV_STEPS][c] > QONE) ? QONE : dv_quo[DV_STEPS][c];
      if (dv_it[DV_STEPS].zero) begin
        r_nxt[c] = '0;
      end else if (dv_it[DV_STEPS].neg[c]) begin
        r_nxt[c] = QW'(-qs[c]);
      end else begin
        r_nxt[c] = QW'(qs[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[DV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r_r    <= r_nxt;
      out_zero_r <= dv_it[DV_STEPS].zero;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_r_w          = out_r_r[0];
  assign out_r_i          = out_r_r[1];
  assign out_r_j          = out_r_r[2];
  assign out_r_k          = out_r_r[3];
  assign out_zero_product = out_zero_r;

`ifndef SYNTH
  // zero product gives an all-zero quaternion
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |->
      out_r_r[0] == '0 && out_r_r[1] == '0 && out_r_r[2] == '0 && out_r_r[3] == '0)
    else $error("zero product with nonzero components");

  // every component stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_r_r[0] <= 16384 && out_r_r[0] >= -16384 &&
      out_r_r[1] <= 16384 && out_r_r[1] >= -16384 &&
      out_r_r[2] <= 16384 && out_r_r[2] >= -16384 &&
      out_r_r[3] <= 16384 && out_r_r[3] >= -16384)
    else $error("normalised component out of range");

  // a nonzero product has a magnitude of at least 2^30 at the end of the root chain
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    sr_v[SQ_STEPS] && !sr_it[SQ_STEPS].zero |-> sr_root[SQ_STEPS][ROOTW-1:ROOTW-2] != 2'b00)
    else $error("square root below normalised range");

  // a stalled output freezes the last stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r_r[0]) && $stable(out_zero_r))
    else $error("output changed while stalled");
`endif

endmodule

/* tb/qmn_checker.sv */
// Checker for the normalised quaternion product: watches both channels,
// predicts each result and compares it. Depends on qmn_pkg for the field width.
`timescale 1ns / 1ps
module qmn_checker
  import qmn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [QW-1:0] in_a_w,
  input  logic signed [QW-1:0] in_a_i,
  input  logic signed [QW-1:0] in_a_j,
  input  logic signed [QW-1:0] in_a_k,
  input  logic signed [QW-1:0] in_b_w,
  input  logic signed [QW-1:0] in_b_i,
  input  logic signed [QW-1:0] in_b_j,
  input  logic signed [QW-1:0] in_b_k,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [QW-1:0] out_r_w,
  input  logic signed [QW-1:0] out_r_i,
  input  logic signed [QW-1:0] out_r_j,
  input  logic signed [QW-1:0] out_r_k,
  input  logic                 out_zero_product,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [3:0][QW-1:0] r;
    logic               zero;
  } unit_quat_t;

  unit_quat_t unit_q[$];

  // Floor square root by bisection
  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [32:0] lo, hi, mid;
    lo = 0;
    hi = 33'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (64'(mid) * 64'(mid) <= v) lo = mid;
      else hi = mid;
    end
    return lo[31:0];
  endfunction

  // Hamilton product, then normalise to Q1.14 with rounding and saturation
  function automatic unit_quat_t normalised_product(
      logic signed [QW-1:0] aw, ai, aj, ak, bw, bi, bj, bk);
    unit_quat_t res;
    longint p [4];
    logic [63:0] m [4];
    logic [63:0] maxm, s, mag, q;
    int top;
    p[0] = aw*bw - ai*bi - aj*bj - ak*bk;
    p[1] = aw*bi + ai*bw + aj*bk - ak*bj;
    p[2] = aw*bj - ai*bk + aj*bw + ak*bi;
    p[3] = aw*bk + ai*bj - aj*bi + ak*bw;
    maxm = 0;
    for (int c = 0; c < 4; c++) begin
      m[c] = (p[c] < 0) ? -p[c] : p[c];
      if (m[c] > maxm) maxm = m[c];
    end
    res = '0;
    if (maxm == 0) begin
      res.zero = 1'b1;
      return res;
    end
    top = 0;
    while (top < 63 && (maxm >> (top + 1)) != 0) top++;
    s = 0;
    for (int c = 0; c < 4; c++) begin
      if (top < 30) m[c] = m[c] << (30 - top);
      else if (top > 30) m[c] = m[c] >> (top - 30);
      s += m[c] * m[c];
    end
    mag = root_floor(s);
    for (int c = 0; c < 4; c++) begin
      q = ((m[c] << 15) + mag) / (2 * mag);
      if (q > 16384) q = 16384;
      res.r[c] = (p[c] < 0) ? QW'(-q) : QW'(q);
    end
    return res;
  endfunction

  assign pending = unit_q.size();

  always @(posedge clk) begin
    unit_quat_t exp_q, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        unit_q.push_back(normalised_product(in_a_w, in_a_i, in_a_j, in_a_k,
                                            in_b_w, in_b_i, in_b_j, in_b_k));
      if (out_valid && out_ready) begin
        got.r = {out_r_k, out_r_j, out_r_i, out_r_w};
        got.zero = out_zero_product;
        if (unit_q.size() == 0) begin
          if (fail_count < 10) $display("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_q = unit_q.pop_front();
          if (exp_q != got) begin
            if (fail_count < 10)
              $display("mismatch: exp w=%0d i=%0d j=%0d k=%0d z=%0b got w=%0d i=%0d j=%0d k=%0d z=%0b",
                       $signed(exp_q.r[0]), $signed(exp_q.r[1]), $signed(exp_q.r[2]),
                       $signed(exp_q.r[3]), exp_q.zero, out_r_w, out_r_i, out_r_j,
                       out_r_k, out_zero_product);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/tb_quaternion_multiply_normalize.sv */
// Testbench top for quaternion_multiply_normalize: drives directed and random
// transactions with random idling. Depends on qmn_pkg and qmn_checker.
`timescale 1ns / 1ps
module tb_quaternion_multiply_normalize;
  import qmn_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0, out_zero_product;
  logic signed [QW-1:0] a_w = '0, a_i = '0, a_j = '0, a_k = '0;
  logic signed [QW-1:0] b_w = '0, b_i = '0, b_j = '0, b_k = '0;
  logic signed [QW-1:0] r_w, r_i, r_j, r_k;
  int fail_count, pending;
  int send_idle = 32, recv_idle = 46;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  quaternion_multiply_normalize u_top (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_a_w(a_w), .in_a_i(a_i), .in_a_j(a_j), .in_a_k(a_k),
    .in_b_w(b_w), .in_b_i(b_i), .in_b_j(b_j), .in_b_k(b_k),
    .out_valid, .out_ready,
    .out_r_w(r_w), .out_r_i(r_i), .out_r_j(r_j), .out_r_k(r_k),
    .out_zero_product
  );

  qmn_checker u_check (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_a_w(a_w), .in_a_i(a_i), .in_a_j(a_j), .in_a_k(a_k),
    .in_b_w(b_w), .in_b_i(b_i), .in_b_j(b_j), .in_b_k(b_k),
    .out_valid, .out_ready,
    .out_r_w(r_w), .out_r_i(r_i), .out_r_j(r_j), .out_r_k(r_k),
    .out_zero_product, .fail_count, .pending
  );

  // Receiver stalls at random
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle);

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb_quaternion_multiply_normalize NOT OK");
      $finish;
    end
  end

  // Random component: full range half the time, else an extreme, a small value or 1.0
  function automatic logic [QW-1:0] pick_component();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(8)) - 4);
      3: return 16'sh4000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One transaction: optional idle gap, then hold valid until accepted;
  // valid drops only in an idle cycle, so back-to-back sends keep it high
  task automatic send_quats(input logic [7:0][QW-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {b_k, b_j, b_i, b_w, a_k, a_j, a_i, a_w} <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_batch(input int count);
    logic [7:0][QW-1:0] v;
    for (int n = 0; n < count; n++) begin
      for (int f = 0; f < 8; f++) v[f] = pick_component();
      // occasional zero or pure-scalar operand
      if ($urandom_range(19) == 0) v[3:0] = '0;
      if ($urandom_range(19) == 0) v[7:5] = '0;
      send_quats(v);
    end
  endtask

  initial begin
    logic [7:0][QW-1:0] v;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero product, identities, extremes, single axes
    send_quats('0);
    send_quats({16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh0});
    send_quats({16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh4000});
    send_quats({8{16'sh8000}});
    send_quats({8{16'sh7fff}});
    send_quats({{4{16'sh7fff}}, {4{16'sh8000}}});
    send_quats({8{16'shffff}});
    send_quats({8{16'sh0001}});
    for (int f = 0; f < 4; f++) begin
      v = '0;
      v[f] = 16'sh4000;
      v[4 + ((f + 1) % 4)] = 16'shc000;
      send_quats(v);
    end
    send_quats({16'sh0, 16'sh0, 16'sh0, 16'sh1, 16'sh0, 16'sh0, 16'sh1, 16'sh0});
    send_quats({16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});

    random_batch(450);
    send_idle = 46;
    recv_idle = 32;
    random_batch(450);
    send_idle = 0;
    recv_idle = 0;
    random_batch(450);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("tb_quaternion_multiply_normalize OK");
    else $display("tb_quaternion_multiply_normalize NOT OK");
    $finish;
  end

endmodule
